@@ src/rts_pkg.sv @@
// Shared types, codes and constants for the I2C register transfer sequencer.
// No dependencies; every other file in src refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rts_pkg;

	localparam int COUNT_WIDTH_DEF = 8;

	// Command codes.
	localparam logic [1:0] CMD_RESET   = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_PROCESS = 2'd3;

	// Sequencer phases.
	localparam logic [3:0] PH_IDLE         = 4'd0;
	localparam logic [3:0] PH_START        = 4'd1;
	localparam logic [3:0] PH_START_WAIT   = 4'd2;
	localparam logic [3:0] PH_RESTART_WAIT = 4'd3;
	localparam logic [3:0] PH_WRITE_WAIT   = 4'd4;
	localparam logic [3:0] PH_READ_WAIT    = 4'd5;
	localparam logic [3:0] PH_HALTED       = 4'd8;

	// Result kinds.
	localparam logic [2:0] K_STATUS = 3'd0;
	localparam logic [2:0] K_ADDR   = 3'd1;
	localparam logic [2:0] K_DATA   = 3'd2;
	localparam logic [2:0] K_CTRL   = 3'd3;
	localparam logic [2:0] K_RX     = 3'd4;

	// Control register flags.
	localparam logic [7:0] F_RUN   = 8'h01;
	localparam logic [7:0] F_START = 8'h02;
	localparam logic [7:0] F_STOP  = 8'h04;
	localparam logic [7:0] F_ACK   = 8'h08;

	localparam logic       READ_BIT      = 1'b1;
	localparam logic [6:0] SLAVE_RESET   = 7'd111;
	localparam int         MAX_RESULTS   = 3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [7:0] buffer_index;
	} res_t;

	// Everything one step hands to the result buffer.
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] ent;
		logic [1:0]             count;
		logic [3:0]             phase;
	} step_out_t;

endpackage

`default_nettype wire

@@ src/rts_core.sv @@
// Sequencer state, slave address register and the single-step transition logic.
// Depends on rts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rts_core #(
	parameter int COUNT_WIDTH = rts_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [6:0]        cfg_wr_data,
	input  wire logic              step_en,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        byte_count,
	input  wire logic [7:0]        tx_data,
	input  wire logic              controller_ready,
	input  wire logic              bus_busy,
	input  wire logic              address_nack,
	input  wire logic              data_nack,
	input  wire logic [7:0]        rx_data,
	output rts_pkg::step_out_t     step_out
);

	localparam int CW   = COUNT_WIDTH;
	localparam int IDXW = (CW > 8) ? CW : 8;

	logic [6:0]    slave_q;
	logic [3:0]    phase_q;
	logic [CW-1:0] index_q;
	logic [CW-1:0] total_q;
	logic          read_q;

	logic [3:0]    phase_d;
	logic [CW-1:0] index_d;
	logic [CW-1:0] total_d;
	logic          read_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= rts_pkg::SLAVE_RESET;
		end else if (cfg_wr_en) begin
			slave_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rts_pkg::PH_IDLE;
			index_q <= '0;
			total_q <= '0;
			read_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			index_q <= index_d;
			total_q <= total_d;
			read_q  <= read_d;
		end
	end

	always_comb begin
		logic [IDXW-1:0] cnt_ext;
		logic [IDXW-1:0] idx_ext;
		logic [CW-1:0]   count;
		logic [CW-1:0]   idx_inc;
		logic [7:0]      idx8;
		logic [7:0]      addr_wr;
		logic [7:0]      addr_rd;
		logic            proc;
		rts_pkg::res_t   status;

		cnt_ext = IDXW'(byte_count);
		count   = cnt_ext[CW-1:0];

		phase_d = phase_q;
		index_d = index_q;
		total_d = total_q;
		read_d  = read_q;
		proc    = (cmd == rts_pkg::CMD_PROCESS);

		status.kind         = rts_pkg::K_STATUS;
		status.value        = 8'd0;
		status.buffer_index = 8'd0;
		step_out.ent   = {rts_pkg::MAX_RESULTS{status}};
		step_out.count = 2'd0;

		// The command part runs first; a start command then processes at once.
		if (cmd == rts_pkg::CMD_RESET) begin
			phase_d = rts_pkg::PH_IDLE;
			index_d = '0;
			total_d = '0;
			read_d  = 1'b0;
		end else if ((cmd == rts_pkg::CMD_WRITE || cmd == rts_pkg::CMD_READ) &&
				phase_q != rts_pkg::PH_HALTED) begin
			phase_d = rts_pkg::PH_START;
			index_d = '0;
			total_d = count;
			read_d  = (cmd == rts_pkg::CMD_READ);
			proc    = 1'b1;
		end

		idx_ext = IDXW'(index_d);
		idx8    = idx_ext[7:0];
		idx_inc = index_d + CW'(1);
		addr_wr = {slave_q, 1'b0};
		addr_rd = {slave_q, rts_pkg::READ_BIT};

		if (proc) begin
			unique case (phase_d)
				rts_pkg::PH_IDLE: begin
					index_d = '0;
				end
				rts_pkg::PH_START: begin
					if (!bus_busy) begin
						step_out.ent[0] = '{rts_pkg::K_ADDR, addr_wr, 8'd0};
						step_out.ent[1] = '{rts_pkg::K_DATA, tx_data, idx8};
						step_out.ent[2] = '{rts_pkg::K_CTRL,
							rts_pkg::F_RUN | rts_pkg::F_START, 8'd0};
						step_out.count  = 2'd3;
						index_d = idx_inc;
						phase_d = rts_pkg::PH_START_WAIT;
					end
				end
				rts_pkg::PH_START_WAIT: begin
					if (controller_ready) begin
						if (address_nack) begin
							phase_d = rts_pkg::PH_HALTED;
						end else if (index_d >= total_d) begin
							// Nothing beyond the register address: just stop.
							step_out.ent[0] = '{rts_pkg::K_CTRL, rts_pkg::F_STOP, 8'd0};
							step_out.count  = 2'd1;
							phase_d = rts_pkg::PH_WRITE_WAIT;
						end else if (read_d) begin
							step_out.ent[0] = '{rts_pkg::K_ADDR, addr_rd, 8'd0};
							step_out.ent[1] = '{rts_pkg::K_CTRL,
								rts_pkg::F_RUN | rts_pkg::F_START |
								((idx_inc == total_d) ? rts_pkg::F_STOP : rts_pkg::F_ACK),
								8'd0};
							step_out.count  = 2'd2;
							phase_d = rts_pkg::PH_RESTART_WAIT;
						end else begin
							step_out.ent[0] = '{rts_pkg::K_DATA, tx_data, idx8};
							step_out.ent[1] = '{rts_pkg::K_CTRL,
								rts_pkg::F_RUN |
								((idx_inc < total_d) ? 8'd0 : rts_pkg::F_STOP), 8'd0};
							step_out.count  = 2'd2;
							index_d = idx_inc;
							phase_d = rts_pkg::PH_WRITE_WAIT;
						end
					end
				end
				rts_pkg::PH_RESTART_WAIT, rts_pkg::PH_READ_WAIT: begin
					if (controller_ready) begin
						if (phase_d == rts_pkg::PH_RESTART_WAIT && address_nack) begin
							phase_d = rts_pkg::PH_HALTED;
						end else begin
							step_out.ent[0] = '{rts_pkg::K_RX, rx_data, idx8};
							index_d = idx_inc;
							if (idx_inc < total_d) begin
								// The last byte to read gets STOP, the others ACK.
								step_out.ent[1] = '{rts_pkg::K_CTRL,
									rts_pkg::F_RUN |
									((idx_inc + CW'(1) == total_d) ?
										rts_pkg::F_STOP : rts_pkg::F_ACK),
									8'd0};
								step_out.count  = 2'd2;
								phase_d = rts_pkg::PH_READ_WAIT;
							end else begin
								step_out.count = 2'd1;
								phase_d = rts_pkg::PH_IDLE;
								index_d = '0;
							end
						end
					end
				end
				rts_pkg::PH_WRITE_WAIT: begin
					if (controller_ready) begin
						if (data_nack) begin
							phase_d = rts_pkg::PH_HALTED;
						end else if (index_d < total_d) begin
							step_out.ent[0] = '{rts_pkg::K_DATA, tx_data, idx8};
							step_out.ent[1] = '{rts_pkg::K_CTRL,
								rts_pkg::F_RUN |
								((idx_inc < total_d) ? 8'd0 : rts_pkg::F_STOP), 8'd0};
							step_out.count  = 2'd2;
							index_d = idx_inc;
						end else begin
							phase_d = rts_pkg::PH_IDLE;
							index_d = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// A step that issues nothing still reports one status word.
		if (step_out.count == 2'd0) begin
			step_out.count = 2'd1;
		end
		step_out.phase = phase_d;
	end

endmodule

`default_nettype wire

@@ src/rts_result_buf.sv @@
// Result buffer: holds the words of one step and hands them out one per handshake.
// Depends on rts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rts_result_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire rts_pkg::step_out_t step_in,
	output logic                    room,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [2:0]              kind,
	output logic [7:0]              value,
	output logic [7:0]              buffer_index,
	output logic [3:0]              phase,
	output logic                    last
);

	rts_pkg::res_t [rts_pkg::MAX_RESULTS-1:0] ent_q;
	logic [3:0] phase_q;
	logic [1:0] count_q;
	logic [1:0] rd_q;
	logic       pop;
	rts_pkg::res_t cur;

	assign res_valid = (rd_q != count_q);
	assign last      = res_valid && (rd_q + 2'd1 == count_q);
	assign pop       = res_valid && !res_stall;
	// A new step may load when the buffer is empty or its final word leaves now.
	assign room      = !res_valid || (pop && last);

	always_comb begin
		if (rd_q == 2'd2) begin
			cur = ent_q[2];
		end else if (rd_q == 2'd1) begin
			cur = ent_q[1];
		end else begin
			cur = ent_q[0];
		end
	end

	assign kind         = cur.kind;
	assign value        = cur.value;
	assign buffer_index = cur.buffer_index;
	assign phase        = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_q    <= 2'd0;
		end else if (load) begin
			count_q <= step_in.count;
			rd_q    <= 2'd0;
		end else if (pop && last) begin
			count_q <= 2'd0;
			rd_q    <= 2'd0;
		end else if (pop) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q   <= step_in.ent;
			phase_q <= step_in.phase;
		end
	end

endmodule

`default_nettype wire

@@ src/i2c_register_transfer_sequencer.sv @@
// An accepted command word is registered, then steps into the result buffer when it has room.
// Throughput: one command word per cycle while each step yields a single result and the
// receiver does not stall; a multi-result step holds the output until its last word leaves.
// Reset: asynchronous, active low; phase idle, counters cleared, slave address 111.
// Depends on rts_pkg, rts_core and rts_result_buf.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transfer_sequencer #(
	parameter int COUNT_WIDTH = rts_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [6:0] cfg_wr_data,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] byte_count,
	input  wire logic [7:0] tx_data,
	input  wire logic       controller_ready,
	input  wire logic       bus_busy,
	input  wire logic       address_nack,
	input  wire logic       data_nack,
	input  wire logic [7:0] rx_data,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [2:0]      kind,
	output logic [7:0]      value,
	output logic [7:0]      buffer_index,
	output logic [3:0]      phase,
	output logic            last
);

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_count_s1;
	logic [7:0] tx_data_s1;
	logic       ready_s1;
	logic       busy_s1;
	logic       anack_s1;
	logic       dnack_s1;
	logic [7:0] rx_data_s1;

	logic               room;
	logic               advance;
	logic               accept;
	rts_pkg::step_out_t step_out;

	assign advance   = valid_s1 && room;
	assign cmd_stall = valid_s1 && !room;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1        <= cmd;
			byte_count_s1 <= byte_count;
			tx_data_s1    <= tx_data;
			ready_s1      <= controller_ready;
			busy_s1       <= bus_busy;
			anack_s1      <= address_nack;
			dnack_s1      <= data_nack;
			rx_data_s1    <= rx_data;
		end
	end

	rts_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.step_en          (advance),
		.cmd              (cmd_s1),
		.byte_count       (byte_count_s1),
		.tx_data          (tx_data_s1),
		.controller_ready (ready_s1),
		.bus_busy         (busy_s1),
		.address_nack     (anack_s1),
		.data_nack        (dnack_s1),
		.rx_data          (rx_data_s1),
		.step_out         (step_out)
	);

	rts_result_buf u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.step_in      (step_out),
		.room         (room),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.value        (value),
		.buffer_index (buffer_index),
		.phase        (phase),
		.last         (last)
	);

endmodule

`default_nettype wire

@@ src/rts_checker.sv @@
// Port-level checks for the sequencer, attached to the top level by bind.
// Depends on rts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rts_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic [2:0] kind,
	input wire logic [7:0] value,
	input wire logic [7:0] buffer_index,
	input wire logic [3:0] phase,
	input wire logic       last
);

	// A stalled result word holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(value) &&
			$stable(buffer_index) && $stable(phase) && $stable(last))
		else $error("result word changed while stalled");

	// A status word is only ever the sole word of its step.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rts_pkg::K_STATUS |-> last)
		else $error("status word not marked last");

	// Entering the halted phase issues nothing to the controller.
	a_halted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase == rts_pkg::PH_HALTED |-> kind == rts_pkg::K_STATUS && last)
		else $error("register write issued in halted phase");

	// An address write is always followed by more words in the same step.
	a_addr_follow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rts_pkg::K_ADDR |-> !last)
		else $error("address write ended a step");

endmodule

bind i2c_register_transfer_sequencer rts_checker u_rts_checker (.*);

`default_nettype wire

@@ bench/tb_i2c_register_transfer_sequencer.sv @@
// Self-checking testbench for the I2C register transfer sequencer.
// A scoreboard class predicts every result word from the accepted command words.
// Depends on rts_pkg and the block i2c_register_transfer_sequencer.
`timescale 1ns / 1ps

module tb_i2c_register_transfer_sequencer;
	import rts_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int WORDS_PER_SEGMENT = 105;
	localparam int SEGMENTS = 4;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [1:0] STALL_NONE = 2'd0;
	localparam logic [1:0] STALL_RANDOM = 2'd1;
	localparam logic [1:0] STALL_PERIODIC = 2'd2;

	class xfer_scoreboard;
		typedef struct {
			logic [2:0] kind;
			logic [7:0] value;
			logic [7:0] index;
			logic [3:0] phase;
			logic       last;
		} expected_word_t;

		logic [6:0] addr7;
		logic [3:0] cur_phase;
		logic [7:0] byte_pos;
		logic [7:0] byte_total;
		logic       reading;
		int         errors;
		expected_word_t pending_q[$];
		expected_word_t step_words[$];

		function new();
			addr7 = SLAVE_RESET;
			cur_phase = PH_IDLE;
			byte_pos = '0;
			byte_total = '0;
			reading = 1'b0;
			errors = 0;
		endfunction

		function void set_address(logic [6:0] a);
			addr7 = a;
		endfunction

		function void stage(logic [2:0] k, logic [7:0] v, logic [7:0] idx);
			expected_word_t e;
			e.kind = k;
			e.value = v;
			e.index = idx;
			e.phase = '0;
			e.last = 1'b0;
			step_words.push_back(e);
		endfunction

		// Issue the control word for the next received byte, or close the read.
		function void request_read(logic [7:0] extra);
			if (byte_pos < byte_total) begin
				stage(K_CTRL, F_RUN | extra |
					((byte_total - byte_pos == 8'd1) ? F_STOP : F_ACK), 8'd0);
				cur_phase = (extra != 8'd0) ? PH_RESTART_WAIT : PH_READ_WAIT;
			end else begin
				cur_phase = PH_IDLE;
				byte_pos = '0;
			end
		endfunction

		function void send_data(logic [7:0] tx);
			stage(K_DATA, tx, byte_pos);
			byte_pos = byte_pos + 8'd1;
			stage(K_CTRL, F_RUN | ((byte_pos < byte_total) ? 8'd0 : F_STOP), 8'd0);
			cur_phase = PH_WRITE_WAIT;
		endfunction

		function void note_word(logic [1:0] op, logic [7:0] count, logic [7:0] tx,
				logic ready, logic busy, logic anack, logic dnack, logic [7:0] rx);
			bit advance;
			advance = (op == CMD_PROCESS);
			step_words.delete();
			if (op == CMD_RESET) begin
				cur_phase = PH_IDLE;
				byte_pos = '0;
				byte_total = '0;
				reading = 1'b0;
			end else if ((op == CMD_WRITE || op == CMD_READ) && cur_phase != PH_HALTED) begin
				cur_phase = PH_START;
				byte_pos = '0;
				byte_total = count;
				reading = (op == CMD_READ);
				advance = 1'b1;
			end
			if (advance) begin
				case (cur_phase)
				PH_IDLE: byte_pos = '0;
				PH_START: if (!busy) begin
					stage(K_ADDR, {addr7, 1'b0}, 8'd0);
					stage(K_DATA, tx, byte_pos);
					byte_pos = byte_pos + 8'd1;
					stage(K_CTRL, F_RUN | F_START, 8'd0);
					cur_phase = PH_START_WAIT;
				end
				PH_START_WAIT: if (ready) begin
					if (anack) begin
						cur_phase = PH_HALTED;
					end else if (byte_pos >= byte_total) begin
						// Only the register address was sent, so just stop.
						stage(K_CTRL, F_STOP, 8'd0);
						cur_phase = PH_WRITE_WAIT;
					end else if (reading) begin
						stage(K_ADDR, {addr7, READ_BIT}, 8'd0);
						request_read(F_START);
					end else begin
						send_data(tx);
					end
				end
				PH_RESTART_WAIT, PH_READ_WAIT: if (ready) begin
					// Nacks are only honored while the repeated start completes.
					if (cur_phase == PH_RESTART_WAIT && anack) begin
						cur_phase = PH_HALTED;
					end else begin
						stage(K_RX, rx, byte_pos);
						byte_pos = byte_pos + 8'd1;
						request_read(8'd0);
					end
				end
				PH_WRITE_WAIT: if (ready) begin
					if (dnack) begin
						cur_phase = PH_HALTED;
					end else if (byte_pos < byte_total) begin
						send_data(tx);
					end else begin
						cur_phase = PH_IDLE;
						byte_pos = '0;
					end
				end
				default: ;
				endcase
			end
			if (step_words.size() == 0)
				stage(K_STATUS, 8'd0, 8'd0);
			foreach (step_words[i]) begin
				step_words[i].phase = cur_phase;
				step_words[i].last = (i == step_words.size() - 1);
				pending_q.push_back(step_words[i]);
			end
		endfunction

		function void check_result(logic [2:0] k, logic [7:0] v, logic [7:0] idx,
				logic [3:0] ph, logic lst);
			expected_word_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result word: kind %0d value %0h phase %0d", k, v, ph);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, k);
				errors++;
			end
			if (v !== e.value) begin
				$error("value: expected %0h, got %0h", e.value, v);
				errors++;
			end
			if (idx !== e.index) begin
				$error("buffer_index: expected %0d, got %0d", e.index, idx);
				errors++;
			end
			if (ph !== e.phase) begin
				$error("phase: expected %0d, got %0d", e.phase, ph);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [1:0] cmd = CMD_RESET;
	logic [7:0] byte_count = '0;
	logic [7:0] tx_data = '0;
	logic       controller_ready = 1'b0;
	logic       bus_busy = 1'b0;
	logic       address_nack = 1'b0;
	logic       data_nack = 1'b0;
	logic [7:0] rx_data = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] value;
	logic [7:0] buffer_index;
	logic [3:0] phase;
	logic       last;

	xfer_scoreboard sb;
	int words_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	logic [1:0] stall_mode = STALL_NONE;
	logic [7:0] stall_tick = '0;

	i2c_register_transfer_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.byte_count(byte_count),
		.tx_data(tx_data),
		.controller_ready(controller_ready),
		.bus_busy(bus_busy),
		.address_nack(address_nack),
		.data_nack(data_nack),
		.rx_data(rx_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.value(value),
		.buffer_index(buffer_index),
		.phase(phase),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Present one command word, hold it until accepted, then maybe pause the sender.
	task automatic send_word(logic [1:0] op, logic [7:0] count, logic [7:0] tx,
			logic ready, logic busy, logic anack, logic dnack, logic [7:0] rx);
		int gap;
		cmd_valid <= 1'b1;
		cmd <= op;
		byte_count <= count;
		tx_data <= tx;
		controller_ready <= ready;
		bus_busy <= busy;
		address_nack <= anack;
		data_nack <= dnack;
		rx_data <= rx;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_word(op, count, tx, ready, busy, anack, dnack, rx);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = chance(10) ? 60 : int'($urandom_range(1, 12));
			if ($urandom_range(0, 3) != 0) begin
				gap = int'($urandom_range(1, 5));
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Let every expected word come out and the pipeline go quiet.
	task automatic wait_drain();
		cmd_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(logic [6:0] a);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_address(a);
	endtask

	// Receiver: switches between no stall, random stall and a periodic stall.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick[5:0] == 6'd0)
			stall_mode <= 2'($urandom_range(0, 2));
		case (stall_mode)
		STALL_NONE: res_stall <= 1'b0;
		STALL_RANDOM: res_stall <= chance(40);
		default: res_stall <= (stall_tick[3:0] >= 4'd10);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(kind, value, buffer_index, phase, last);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int seg;
		int target;
		int steps;
		int cap;
		logic [1:0] op;
		logic [7:0] size;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle process, full write, full read, empty write, abandon, nacks.
		send_word(CMD_PROCESS, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_WRITE, 8'd3, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_READ, 8'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
		send_word(CMD_WRITE, 8'd0, 8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_WRITE, 8'd255, 8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_READ, 8'd1, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_WRITE, 8'd2, 8'h42, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0);
		send_word(CMD_WRITE, 8'd4, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_RESET, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_READ, 8'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0);
		send_word(CMD_RESET, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_WRITE, 8'd3, 8'h99, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h66, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
		send_word(CMD_PROCESS, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 8'd0);
		send_word(CMD_RESET, 8'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_drain();
			case (seg)
			0: write_address(7'd0);
			1: write_address(7'h7F);
			default: write_address(7'($urandom_range(0, 127)));
			endcase
			target = words_sent + WORDS_PER_SEGMENT;
			while (words_sent < target) begin
				if (chance(8)) begin
					// Noise: any command with arbitrary fields.
					send_word(2'($urandom_range(0, 3)), rand_byte(), rand_byte(),
						chance(50), chance(50), chance(50), chance(50), rand_byte());
				end else begin
					op = chance(50) ? CMD_READ : CMD_WRITE;
					if (chance(75))
						size = 8'($urandom_range(0, 5));
					else if (chance(70))
						size = 8'($urandom_range(6, 20));
					else
						size = 8'($urandom_range(21, 255));
					send_word(op, size, rand_byte(), chance(50), chance(25),
						chance(50), chance(50), rand_byte());
					// Long transfers are cut short by the next command.
					cap = int'($urandom_range(1, 40));
					steps = 0;
					while (sb.cur_phase != PH_IDLE && sb.cur_phase != PH_HALTED
							&& steps < cap) begin
						send_word(CMD_PROCESS, rand_byte(), rand_byte(),
							chance(80), chance(25), chance(3), chance(3), rand_byte());
						steps++;
					end
					if (sb.cur_phase == PH_HALTED) begin
						repeat ($urandom_range(0, 2))
							send_word(2'($urandom_range(1, 3)), rand_byte(), rand_byte(),
								chance(50), chance(50), chance(50), chance(50),
								rand_byte());
						send_word(CMD_RESET, rand_byte(), rand_byte(),
							chance(50), chance(50), chance(50), chance(50), rand_byte());
					end
				end
			end
		end

		wait_drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ i2c_register_transfer_sequencer.f @@
src/rts_pkg.sv
src/rts_core.sv
src/rts_result_buf.sv
src/i2c_register_transfer_sequencer.sv
src/rts_checker.sv
bench/tb_i2c_register_transfer_sequencer.sv
